FILE: rtl/core/vertex_normal_accumulator_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef VERTEX_NORMAL_ACCUMULATOR_UNIT_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define VNA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vna assertion failed");

// Next-cycle implication, reset-qualified.
`define VNA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vna assertion failed");

`endif

FILE: rtl/core/vna_pkg.sv
// Shared types, constants and helpers of the vertex normal accumulator.
package vna_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int IDX_W            = 10;
    localparam int POS_W            = 16;
    localparam int SUM_W            = 24;
    localparam int NRM_W            = 16;
    localparam int MAG_W            = 36;
    localparam int ONE_Q14          = 16384;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_TRI    = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef struct packed {
        logic               en;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } mul_req_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] s,
        input logic signed [NRM_W-1:0] n
    );
        logic signed [SUM_W:0] t;
        t = {s[SUM_W-1], s} + {{(SUM_W+1-NRM_W){n[NRM_W-1]}}, n};
        if (t[SUM_W] != t[SUM_W-1])
        begin
            return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return t[SUM_W-1:0];
    endfunction

endpackage

FILE: rtl/core/vna_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/vna_mul.sv
// Shared signed 32x32 multiplier with registered product.
module vna_mul (
    input  logic               clk,
    input  vna_pkg::mul_req_t  req,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/vertex_normal_accumulator_unit.sv
// Top level of the vertex normal accumulator: sequencer, datapath and stores.
//
// Smooth per-vertex normals. Each input transaction appends a Q8.8 position,
// adds a triangle, reads one vertex normal (Q1.14) or clears the store; only a
// read returns a result transaction. A triangle's face normal
// cross(p2-p0, p1-p0) is made unit length and added, saturating, to the 24-bit
// accumulators of its three corners; triangles with an out-of-range corner or
// a zero cross product are dropped. A read of a vertex whose squared sum is at
// most 2 gives (0, 1.0, 0); a read past the vertex count gives zeros with
// index_ok low. Timing: one transaction at a time, item_stall is high while
// it runs. A triangle with a bad corner or a zero cross product, a read past
// the vertex count and a read of a short sum finish before the normalizing.
// A finishing read also waits while the previous result is still held. The
// time taken is set by the one shared multiplier, the single-bit normalizing
// shifts, the bit-pair square root loop and the bit-serial divider that
// produces each 15-bit component. A finished read result sits in an output
// register; the next transaction is accepted while it waits, and only a new
// read result waits for it to be taken. Positions and sums live in RAMs, no
// clearing pass: an append zeroes its vertex's sums.
module vertex_normal_accumulator_unit #(
    parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [1:0]                      func,
    input  logic signed [vna_pkg::POS_W-1:0] pos_x,
    input  logic signed [vna_pkg::POS_W-1:0] pos_y,
    input  logic signed [vna_pkg::POS_W-1:0] pos_z,
    input  logic [vna_pkg::IDX_W-1:0]       corner_a,
    input  logic [vna_pkg::IDX_W-1:0]       corner_b,
    input  logic [vna_pkg::IDX_W-1:0]       corner_c,
    input  logic [vna_pkg::IDX_W-1:0]       read_index,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic signed [vna_pkg::NRM_W-1:0] normal_x,
    output logic signed [vna_pkg::NRM_W-1:0] normal_y,
    output logic signed [vna_pkg::NRM_W-1:0] normal_z,
    output logic                            index_ok
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CW > vna_pkg::IDX_W) ? CW : vna_pkg::IDX_W;
    localparam int PW   = 3 * vna_pkg::POS_W;
    localparam int SW   = 3 * vna_pkg::SUM_W;
    localparam int MW   = vna_pkg::MAG_W;
    localparam int NW   = vna_pkg::NRM_W;
    localparam int SUMW = vna_pkg::SUM_W;

    typedef enum logic [21:0] {
        S_IDLE = 22'h000001,
        S_LAST = 22'h000002,
        S_PRD  = 22'h000004,
        S_PWT  = 22'h000008,
        S_CMUL = 22'h000010,
        S_CACC = 22'h000020,
        S_CZ   = 22'h000040,
        S_NRM0 = 22'h000080,
        S_NORM = 22'h000100,
        S_SQM  = 22'h000200,
        S_SQA  = 22'h000400,
        S_ROOT = 22'h000800,
        S_DIVI = 22'h001000,
        S_DIV  = 22'h002000,
        S_ARD  = 22'h004000,
        S_AWR  = 22'h008000,
        S_SRD  = 22'h010000,
        S_SWT  = 22'h020000,
        S_QM   = 22'h040000,
        S_QA   = 22'h080000,
        S_QD   = 22'h100000,
        S_FIN  = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    // control
    logic [CW-1:0]             count_reg;
    logic [2:0]                step_reg;
    logic [3:0]                dcnt_reg;
    logic [1:0]                func_reg;
    logic [vna_pkg::IDX_W-1:0] idx_reg [3];
    logic                      result_valid_reg;
    logic                      ok_reg;

    // payload
    logic [PW-1:0]                 pa_reg;
    logic signed [16:0]            e1_reg [3];
    logic signed [16:0]            e2_reg [3];
    logic signed [MW-1:0]          vec_reg [3];
    logic [MW-1:0]                 mag_reg [3];
    logic                          neg_reg [3];
    logic signed [63:0]            acc_reg;
    logic [62:0]                   rem_reg, res_reg, bit_reg;
    logic [30:0]                   len_reg;
    logic [45:0]                   drem_reg, den_reg;
    logic [14:0]                   q_reg;
    logic signed [NW-1:0]          nq_reg [3];
    logic signed [NW-1:0]          normal_x_reg, normal_y_reg, normal_z_reg;

    // stores
    logic            pos_we;
    logic [AW-1:0]   pos_waddr, pos_raddr;
    logic [PW-1:0]   pos_wdata, pos_rdata;
    logic            sum_we;
    logic [AW-1:0]   sum_waddr, sum_raddr;
    logic [SW-1:0]   sum_wdata, sum_rdata;

    vna_pkg::mul_req_t  mreq;
    logic signed [63:0] prod;

    logic       accept;
    logic [1:0] k;
    logic       tri_ok, rd_ok;
    logic       mag_big, mag_small;
    logic [62:0] root_try;
    logic        root_ge;
    logic [62:0] res_step;
    logic        q_bit;
    logic [14:0] q_full;
    logic [AW-1:0] idx_addr;
    logic [PW-1:0] pos_in;

    vna_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    vna_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign k          = step_reg[1:0];

    // index checks against the current vertex count
    assign tri_ok = (CMPW'(corner_a) < CMPW'(count_reg)) &&
                    (CMPW'(corner_b) < CMPW'(count_reg)) &&
                    (CMPW'(corner_c) < CMPW'(count_reg));
    assign rd_ok  = (CMPW'(read_index) < CMPW'(count_reg));

    // normalizer window [2^29, 2^30) on the largest magnitude
    assign mag_big   = (|mag_reg[0][MW-1:30]) || (|mag_reg[1][MW-1:30]) ||
                       (|mag_reg[2][MW-1:30]);
    assign mag_small = !(|mag_reg[0][MW-1:29]) && !(|mag_reg[1][MW-1:29]) &&
                       !(|mag_reg[2][MW-1:29]);

    // square root: one bit pair per cycle
    assign root_try = res_reg + bit_reg;
    assign root_ge  = (rem_reg >= root_try);
    assign res_step = root_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    // restoring divider: one quotient bit per cycle
    assign q_bit  = (drem_reg >= den_reg);
    assign q_full = {q_reg[13:0], q_bit};

    assign idx_addr = AW'(idx_reg[k]);
    assign pos_in   = {pos_x, pos_y, pos_z};

    // store ports
    always_comb
    begin
        pos_we    = accept && (func == vna_pkg::FUNC_APPEND) &&
                    (count_reg < CW'(MAX_VERTICES));
        pos_waddr = AW'(count_reg);
        pos_wdata = pos_in;
        pos_raddr = idx_addr;

        sum_raddr = (state_reg == S_SRD) ? AW'(idx_reg[0]) : idx_addr;
        if (state_reg == S_AWR)
        begin
            sum_we    = 1'b1;
            sum_waddr = idx_addr;
            sum_wdata = {vna_pkg::sat_add(sum_rdata[SW-1:2*SUMW], nq_reg[0]),
                         vna_pkg::sat_add(sum_rdata[2*SUMW-1:SUMW], nq_reg[1]),
                         vna_pkg::sat_add(sum_rdata[SUMW-1:0], nq_reg[2])};
        end
        else
        begin
            sum_we    = pos_we;
            sum_waddr = AW'(count_reg);
            sum_wdata = '0;
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mreq.en = 1'b0;
        mreq.a  = '0;
        mreq.b  = '0;
        case (state_reg)
            S_CMUL:
            begin
                mreq.en = 1'b1;
                case (step_reg)
                    3'd0:    begin mreq.a = 32'(e1_reg[1]); mreq.b = 32'(e2_reg[2]); end
                    3'd1:    begin mreq.a = 32'(e1_reg[2]); mreq.b = 32'(e2_reg[1]); end
                    3'd2:    begin mreq.a = 32'(e1_reg[2]); mreq.b = 32'(e2_reg[0]); end
                    3'd3:    begin mreq.a = 32'(e1_reg[0]); mreq.b = 32'(e2_reg[2]); end
                    3'd4:    begin mreq.a = 32'(e1_reg[0]); mreq.b = 32'(e2_reg[1]); end
                    default: begin mreq.a = 32'(e1_reg[1]); mreq.b = 32'(e2_reg[0]); end
                endcase
            end
            S_SQM:
            begin
                mreq.en = 1'b1;
                mreq.a  = {2'b00, mag_reg[k][29:0]};
                mreq.b  = {2'b00, mag_reg[k][29:0]};
            end
            S_QM:
            begin
                mreq.en = 1'b1;
                mreq.a  = vec_reg[k][31:0];
                mreq.b  = vec_reg[k][31:0];
            end
            default:
            begin
                mreq.en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        vna_pkg::FUNC_TRI:  state_next = tri_ok ? S_PRD : S_LAST;
                        vna_pkg::FUNC_READ: state_next = rd_ok ? S_SRD : S_FIN;
                        default:            state_next = S_LAST;
                    endcase
                end
            end
            S_LAST: state_next = S_IDLE;
            S_PRD:  state_next = S_PWT;
            S_PWT:  state_next = (step_reg == 3'd2) ? S_CMUL : S_PRD;
            S_CMUL: state_next = S_CACC;
            S_CACC: state_next = (step_reg == 3'd5) ? S_CZ : S_CMUL;
            S_CZ:
            begin
                if (vec_reg[0] == '0 && vec_reg[1] == '0 && vec_reg[2] == '0)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    state_next = S_NRM0;
                end
            end
            S_NRM0: state_next = S_NORM;
            S_NORM: state_next = (!mag_big && !mag_small) ? S_SQM : S_NORM;
            S_SQM:  state_next = S_SQA;
            S_SQA:  state_next = (step_reg == 3'd2) ? S_ROOT : S_SQM;
            S_ROOT: state_next = bit_reg[0] ? S_DIVI : S_ROOT;
            S_DIVI: state_next = S_DIV;
            S_DIV:
            begin
                if (dcnt_reg == 4'd0)
                begin
                    if (step_reg != 3'd2)
                    begin
                        state_next = S_DIVI;
                    end
                    else if (func_reg == vna_pkg::FUNC_TRI)
                    begin
                        state_next = S_ARD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_ARD:  state_next = S_AWR;
            S_AWR:  state_next = (step_reg == 3'd2) ? S_LAST : S_ARD;
            S_SRD:  state_next = S_SWT;
            S_SWT:  state_next = S_QM;
            S_QM:   state_next = S_QA;
            S_QA:   state_next = (step_reg == 3'd2) ? S_QD : S_QM;
            S_QD:   state_next = (acc_reg <= 64'sd2) ? S_FIN : S_NRM0;
            S_FIN:  state_next = (result_valid_reg && result_stall) ? S_FIN : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            step_reg         <= '0;
            dcnt_reg         <= '0;
            func_reg         <= '0;
            result_valid_reg <= 1'b0;
            ok_reg           <= 1'b0;
            idx_reg[0]       <= '0;
            idx_reg[1]       <= '0;
            idx_reg[2]       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // in S_FIN the result register is reloaded below
            if (result_valid_reg && !result_stall && state_reg != S_FIN)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (accept)
                    begin
                        func_reg <= func;
                        ok_reg   <= rd_ok;
                        if (func == vna_pkg::FUNC_READ)
                        begin
                            idx_reg[0] <= read_index;
                        end
                        else
                        begin
                            idx_reg[0] <= corner_a;
                        end
                        idx_reg[1] <= corner_b;
                        idx_reg[2] <= corner_c;
                        if (pos_we)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (func == vna_pkg::FUNC_CLEAR)
                        begin
                            count_reg <= '0;
                        end
                    end
                end
                S_PWT:  step_reg <= (step_reg == 3'd2) ? 3'd0 : step_reg + 3'd1;
                S_CACC: step_reg <= (step_reg == 3'd5) ? 3'd0 : step_reg + 3'd1;
                S_SQA:  step_reg <= (step_reg == 3'd2) ? 3'd0 : step_reg + 3'd1;
                S_DIVI: dcnt_reg <= 4'd14;
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg - 4'd1;
                    if (dcnt_reg == 4'd0)
                    begin
                        step_reg <= (step_reg == 3'd2) ? 3'd0 : step_reg + 3'd1;
                    end
                end
                S_AWR:  step_reg <= step_reg + 3'd1;
                S_QA:   step_reg <= (step_reg == 3'd2) ? 3'd0 : step_reg + 3'd1;
                S_FIN:
                begin
                    if (!(result_valid_reg && result_stall))
                    begin
                        result_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                // defaults for a bad read index
                nq_reg[0] <= '0;
                nq_reg[1] <= '0;
                nq_reg[2] <= '0;
            end
            S_PWT:
            begin
                case (step_reg)
                    3'd0: pa_reg <= pos_rdata;
                    3'd1:
                    begin
                        e2_reg[0] <= {pos_rdata[47], pos_rdata[47:32]} - {pa_reg[47], pa_reg[47:32]};
                        e2_reg[1] <= {pos_rdata[31], pos_rdata[31:16]} - {pa_reg[31], pa_reg[31:16]};
                        e2_reg[2] <= {pos_rdata[15], pos_rdata[15:0]} - {pa_reg[15], pa_reg[15:0]};
                    end
                    default:
                    begin
                        e1_reg[0] <= {pos_rdata[47], pos_rdata[47:32]} - {pa_reg[47], pa_reg[47:32]};
                        e1_reg[1] <= {pos_rdata[31], pos_rdata[31:16]} - {pa_reg[31], pa_reg[31:16]};
                        e1_reg[2] <= {pos_rdata[15], pos_rdata[15:0]} - {pa_reg[15], pa_reg[15:0]};
                    end
                endcase
            end
            S_CACC:
            begin
                if (!step_reg[0])
                begin
                    acc_reg <= prod;
                end
                else
                begin
                    vec_reg[step_reg[2:1]] <= MW'(acc_reg - prod);
                end
            end
            S_NRM0:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= vec_reg[i][MW-1];
                    mag_reg[i] <= vec_reg[i][MW-1] ? MW'(-vec_reg[i]) : vec_reg[i];
                end
            end
            S_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mag_big)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (mag_small)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            S_SQA:
            begin
                acc_reg <= (step_reg == 3'd0) ? prod : acc_reg + prod;
                if (step_reg == 3'd2)
                begin
                    rem_reg <= 63'(acc_reg + prod);
                    res_reg <= '0;
                    bit_reg <= {1'b1, 62'b0};
                end
            end
            S_ROOT:
            begin
                if (root_ge)
                begin
                    rem_reg <= rem_reg - root_try;
                end
                res_reg <= res_step;
                bit_reg <= bit_reg >> 2;
                len_reg <= res_step[30:0];
            end
            S_DIVI:
            begin
                drem_reg <= {2'b00, mag_reg[k][29:0], 14'b0} + {16'b0, len_reg[30:1]};
                den_reg  <= {1'b0, len_reg, 14'b0};
                q_reg    <= '0;
            end
            S_DIV:
            begin
                if (q_bit)
                begin
                    drem_reg <= drem_reg - den_reg;
                end
                den_reg <= den_reg >> 1;
                q_reg   <= q_full;
                if (dcnt_reg == 4'd0)
                begin
                    nq_reg[k] <= neg_reg[k] ? -NW'(q_full) : NW'(q_full);
                end
            end
            S_SWT:
            begin
                vec_reg[0] <= MW'(signed'(sum_rdata[SW-1:2*SUMW]));
                vec_reg[1] <= MW'(signed'(sum_rdata[2*SUMW-1:SUMW]));
                vec_reg[2] <= MW'(signed'(sum_rdata[SUMW-1:0]));
            end
            S_QA:
            begin
                acc_reg <= (step_reg == 3'd0) ? prod : acc_reg + prod;
            end
            S_QD:
            begin
                if (acc_reg <= 64'sd2)
                begin
                    nq_reg[0] <= '0;
                    nq_reg[1] <= NW'(vna_pkg::ONE_Q14);
                    nq_reg[2] <= '0;
                end
            end
            S_FIN:
            begin
                if (!(result_valid_reg && result_stall))
                begin
                    normal_x_reg <= nq_reg[0];
                    normal_y_reg <= nq_reg[1];
                    normal_z_reg <= nq_reg[2];
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // index_ok travels with the result payload
    logic index_ok_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && !(result_valid_reg && result_stall))
        begin
            index_ok_reg <= ok_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign normal_x     = normal_x_reg;
    assign normal_y     = normal_y_reg;
    assign normal_z     = normal_z_reg;
    assign index_ok     = index_ok_reg;

endmodule

FILE: rtl/core/vna_checker.sv
// Port-level checker for the vertex normal accumulator, bound to the top level.
`include "vertex_normal_accumulator_unit_macros.svh"

module vna_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_stall,
    input logic                             result_valid,
    input logic                             result_stall,
    input logic signed [vna_pkg::NRM_W-1:0] normal_x,
    input logic signed [vna_pkg::NRM_W-1:0] normal_y,
    input logic signed [vna_pkg::NRM_W-1:0] normal_z,
    input logic                             index_ok
);

    // a stalled result stays offered
    `VNA_ASSERT_NEXT(a_res_hold, clk, rst_n, result_valid && result_stall, result_valid)
    // a stalled result keeps its payload
    `VNA_ASSERT_NEXT(a_res_stable, clk, rst_n, result_valid && result_stall,
        $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(index_ok))
    // one transaction at a time: busy right after an accept
    `VNA_ASSERT_NEXT(a_busy, clk, rst_n, item_valid && !item_stall, item_stall)
    // bad read index yields a zero vector
    `VNA_ASSERT_NOW(a_bad_idx, clk, rst_n, result_valid && !index_ok,
        normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0)
    // components stay within one unit
    `VNA_ASSERT_NOW(a_range, clk, rst_n, result_valid,
        normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
        normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
        normal_z <= 16'sd16384 && normal_z >= -16'sd16384)

endmodule

bind vertex_normal_accumulator_unit vna_checker u_vna_checker (.*);

FILE: tb/vertex_normal_accumulator_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the vertex normal accumulator unit.
module vertex_normal_accumulator_unit_tb;

    localparam int NV        = 1024;
    localparam int SUM_HI    = 8388607;
    localparam int SUM_LO    = -8388608;
    localparam int QUIET_END = 80;     // transactions at the end with no idling
    localparam int HOLD_LEN  = 400;    // long receiver hold-off, in cycles
    localparam int WD_LIMIT  = 5000;   // cycles with no transaction before giving up

    typedef struct {
        vna_pkg::func_t  op;
        logic signed [15:0] px, py, pz;
        logic [9:0]      ca, cb, cc, ri;
        bit              drain;        // wait for all results before sending
    } mesh_op_t;

    typedef struct {
        logic signed [15:0] nx, ny, nz;
        logic            ok;
    } normal_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               item_valid = 1'b0;
    logic               item_stall;
    logic [1:0]         func = vna_pkg::FUNC_APPEND;
    logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [9:0]         corner_a = '0, corner_b = '0, corner_c = '0, read_index = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic               index_ok;

    vertex_normal_accumulator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .func(func), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
        .read_index(read_index),
        .result_valid(result_valid), .result_stall(result_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .index_ok(index_ok)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Mesh model: positions, saturating sums, vertex count
    // ---------------------------------------------------------------
    int      px_m[NV], py_m[NV], pz_m[NV];
    int      sx_m[NV], sy_m[NV], sz_m[NV];
    int      vcount = 0;

    mesh_op_t mesh_ops[$];
    normal_t  pending_normals[$];

    int  total_ops = 0;
    int  sent_ops = 0;
    int  checked_results = 0;
    int  mismatches = 0;
    int  tri_sent = 0;
    int  read_sent = 0;

    function automatic longint unsigned isqrt(input longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scale magnitudes so the largest sits in [2^29, 2^30), then divide by
    // the integer length with rounding.
    task automatic unit_normal(input longint vx, input longint vy, input longint vz,
                               output int ox, output int oy, output int oz);
        longint unsigned m0, m1, m2, mx, s, len;
        int q0, q1, q2;
        m0 = vx < 0 ? -vx : vx;
        m1 = vy < 0 ? -vy : vy;
        m2 = vz < 0 ? -vz : vz;
        mx = m0 > m1 ? m0 : m1;
        mx = mx > m2 ? mx : m2;
        while (mx >= (64'd1 << 30))
        begin
            m0 >>= 1; m1 >>= 1; m2 >>= 1; mx >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            m0 <<= 1; m1 <<= 1; m2 <<= 1; mx <<= 1;
        end
        s = m0 * m0 + m1 * m1 + m2 * m2;
        len = isqrt(s);
        q0 = int'(((m0 << 14) + (len >> 1)) / len);
        q1 = int'(((m1 << 14) + (len >> 1)) / len);
        q2 = int'(((m2 << 14) + (len >> 1)) / len);
        ox = vx < 0 ? -q0 : q0;
        oy = vy < 0 ? -q1 : q1;
        oz = vz < 0 ? -q2 : q2;
    endtask

    function automatic int clamp_sum(input int a, input int b);
        longint r;
        r = longint'(a) + b;
        if (r > SUM_HI) r = SUM_HI;
        if (r < SUM_LO) r = SUM_LO;
        return int'(r);
    endfunction

    task automatic add_face(input int a, input int b, input int c);
        longint e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
        int nx, ny, nz;
        int vid[3];
        if (a >= vcount || b >= vcount || c >= vcount)
            return;
        e1x = px_m[c] - px_m[a]; e1y = py_m[c] - py_m[a]; e1z = pz_m[c] - pz_m[a];
        e2x = px_m[b] - px_m[a]; e2y = py_m[b] - py_m[a]; e2z = pz_m[b] - pz_m[a];
        cx = e1y * e2z - e1z * e2y;
        cy = e1z * e2x - e1x * e2z;
        cz = e1x * e2y - e1y * e2x;
        if (cx == 0 && cy == 0 && cz == 0)
            return;                        // degenerate face adds nothing
        unit_normal(cx, cy, cz, nx, ny, nz);
        vid[0] = a; vid[1] = b; vid[2] = c;
        foreach (vid[k])
        begin
            sx_m[vid[k]] = clamp_sum(sx_m[vid[k]], nx);
            sy_m[vid[k]] = clamp_sum(sy_m[vid[k]], ny);
            sz_m[vid[k]] = clamp_sum(sz_m[vid[k]], nz);
        end
    endtask

    // Apply one accepted transaction to the model; reads queue a normal.
    task automatic advance_mesh(input mesh_op_t t);
        normal_t e;
        longint sq;
        int nx, ny, nz;
        case (t.op)
            vna_pkg::FUNC_APPEND:
                if (vcount < NV)
                begin
                    px_m[vcount] = int'(t.px);
                    py_m[vcount] = int'(t.py);
                    pz_m[vcount] = int'(t.pz);
                    sx_m[vcount] = 0; sy_m[vcount] = 0; sz_m[vcount] = 0;
                    vcount++;
                end
            vna_pkg::FUNC_TRI:
                add_face(int'(t.ca), int'(t.cb), int'(t.cc));
            vna_pkg::FUNC_CLEAR:
                vcount = 0;
            default:
            begin
                e.nx = '0; e.ny = '0; e.nz = '0; e.ok = 1'b0;
                if (t.ri < vcount)
                begin
                    e.ok = 1'b1;
                    sq = longint'(sx_m[t.ri]) * sx_m[t.ri] +
                         longint'(sy_m[t.ri]) * sy_m[t.ri] +
                         longint'(sz_m[t.ri]) * sz_m[t.ri];
                    if (sq <= 2)
                        e.ny = 16'(vna_pkg::ONE_Q14);    // too short to normalize
                    else
                    begin
                        unit_normal(sx_m[t.ri], sy_m[t.ri], sz_m[t.ri], nx, ny, nz);
                        e.nx = 16'(nx); e.ny = 16'(ny); e.nz = 16'(nz);
                    end
                end
                pending_normals = {pending_normals, e};
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    task automatic push_op(input vna_pkg::func_t op, input int x, input int y, input int z,
                           input int a, input int b, input int c, input int r,
                           input bit drain);
        mesh_op_t t;
        t.op = op;
        t.px = 16'(x); t.py = 16'(y); t.pz = 16'(z);
        t.ca = 10'(a); t.cb = 10'(b); t.cc = 10'(c); t.ri = 10'(r);
        t.drain = drain;
        mesh_ops = {mesh_ops, t};
        total_ops++;
    endtask

    task automatic push_append(input int x, input int y, input int z);
        push_op(vna_pkg::FUNC_APPEND, x, y, z, $urandom, $urandom, $urandom, $urandom, 0);
    endtask

    task automatic push_tri(input int a, input int b, input int c);
        push_op(vna_pkg::FUNC_TRI, $urandom, $urandom, $urandom, a, b, c, $urandom, 0);
    endtask

    task automatic push_read(input int r);
        push_op(vna_pkg::FUNC_READ, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, r, 0);
    endtask

    task automatic push_clear(input bit drain);
        push_op(vna_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, drain);
    endtask

    // Coordinates: mostly moderate, sometimes full range or an extreme.
    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32767 : -32768;
            1, 2:    return int'($signed(16'($urandom)));
            default: return int'($urandom_range(0, 4096)) - 2048;
        endcase
    endfunction

    // One random mesh: clear, a few vertices, then faces, reads and appends, some with bad indices.
    task automatic push_random_mesh();
        int n, nops, k;
        push_clear(1);
        n = $urandom_range(3, 16);
        for (k = 0; k < n; k++)
            push_append(rand_coord(), rand_coord(), rand_coord());
        nops = $urandom_range(6, 20);
        for (k = 0; k < nops; k++)
        begin
            case ($urandom_range(0, 9))
                0:       push_tri($urandom_range(0, 1023), $urandom_range(0, n - 1),
                                  $urandom_range(0, n - 1));
                1:       push_read($urandom_range(0, 1023));
                2:       push_append(rand_coord(), rand_coord(), rand_coord());
                3, 4, 5: push_read($urandom_range(0, n - 1));
                default: push_tri($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                  $urandom_range(0, n - 1));
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: offers the head of mesh_ops, idles in random bursts
    // ---------------------------------------------------------------
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        mesh_op_t t;
        bit       fired;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            fired = item_valid && !item_stall;
            if (fired)
            begin
                t = mesh_ops.pop_front();
                advance_mesh(t);
                sent_ops++;
                if (t.op == vna_pkg::FUNC_TRI) tri_sent++;
                if (t.op == vna_pkg::FUNC_READ) read_sent++;
                if (sent_ops < total_ops - QUIET_END && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 10);
            end
            if (item_valid && !fired)
            begin
                // held: payload stays put
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (mesh_ops.size() > 0 &&
                     (!mesh_ops[0].drain || pending_normals.size() == 0))
            begin
                t = mesh_ops[0];
                item_valid <= 1'b1;
                func       <= t.op;
                pos_x      <= t.px;
                pos_y      <= t.py;
                pos_z      <= t.pz;
                corner_a   <= t.ca;
                corner_b   <= t.cb;
                corner_c   <= t.cc;
                read_index <= t.ri;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks results, drives result_stall (bursts, one long hold)
    // ---------------------------------------------------------------
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 0;

    always @(posedge clk or negedge rst_n)
    begin
        normal_t e;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_normals.size() == 0)
                begin
                    report_mismatch("result transaction count", 1, 0);
                end
                else
                begin
                    e = pending_normals.pop_front();
                    if (normal_x !== e.nx)
                        report_mismatch("normal_x", int'(normal_x), int'(e.nx));
                    if (normal_y !== e.ny)
                        report_mismatch("normal_y", int'(normal_y), int'(e.ny));
                    if (normal_z !== e.nz)
                        report_mismatch("normal_z", int'(normal_z), int'(e.nz));
                    if (index_ok !== e.ok)
                        report_mismatch("index_ok", int'(index_ok), int'(e.ok));
                    checked_results++;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!hold_done && sent_ops >= 120)
            begin
                // long hold-off so the output register fills and input backs up
                hold_done = 1;
                hold_left = HOLD_LEN;
                result_stall <= 1'b1;
            end
            else if (sent_ops >= total_ops - QUIET_END)
                result_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: cycles with no transaction on either channel
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WD_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding", pending_normals.size());
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Stimulus plan and end of run
    // ---------------------------------------------------------------
    initial
    begin
        int k;

        // Directed: extremes, degenerate face, cancelling faces, bad corners,
        // short sum, bad read index.
        push_clear(0);
        push_read(0);                              // empty store
        push_append(-32768, -32768, -32768);       // v0
        push_append(32767, 32767, 32767);          // v1
        push_append(0, 0, 0);                      // v2 (collinear with v0, v1)
        push_append(256, 0, 0);                    // v3
        push_append(0, 256, 0);                    // v4
        push_append(32767, -32768, 100);           // v5
        push_read(0);                              // no faces yet: short sum
        push_tri(0, 1, 2);                         // degenerate
        push_tri(2, 3, 4);
        push_tri(2, 4, 3);                         // cancels the previous one
        push_read(2);
        push_read(3);
        push_tri(0, 1, 5);
        push_tri(0, 1, 1023);                      // corner out of range
        push_tri(6, 1, 0);
        push_read(5);
        push_read(0);
        push_read(6);                              // past vertex count
        push_read(1023);
        push_clear(1);
        push_read(0);

        // Random meshes, first chunk (long receiver hold-off lands here).
        while (total_ops < 300)
            push_random_mesh();

        // Repeated faces: grow the sums of vertex 0 well past one unit.
        push_clear(1);
        push_append(0, 0, 0);
        push_append(256, 0, 0);
        push_append(0, 256, 0);
        push_append(0, 0, -256);
        for (k = 0; k < 150; k++)
        begin
            if ($urandom_range(0, 5) == 0) push_tri(0, 3, 1);
            else                           push_tri(0, 1, 2);
            if (k % 30 == 29) push_read(0);
        end
        push_read(0);
        push_read(1);
        push_read(3);

        // Random meshes, second chunk; the tail runs with no idling.
        k = total_ops;
        while (total_ops < k + 60)
            push_random_mesh();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (sent_ops == total_ops && pending_normals.size() == 0);
        repeat (300) @(posedge clk);

        $display("ran %0d transactions: %0d faces, %0d reads, %0d results checked",
                 sent_ops, tri_sent, read_sent, checked_results);
        $display("covered degenerate and cancelling faces, short sums, large sums, %s",
                 "bad corners, bad read indices and output back-pressure");
        if (mismatches == 0 && pending_normals.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: vertex_normal_accumulator_unit.f
+incdir+rtl/core
rtl/core/vna_pkg.sv
rtl/core/vna_ram.sv
rtl/core/vna_mul.sv
rtl/core/vertex_normal_accumulator_unit.sv
rtl/core/vna_checker.sv
tb/vertex_normal_accumulator_unit_tb.sv
